/* sv/gre_pkg.sv */
// Shared types and constants for the grid rectangle extractor.
`default_nettype none
package gre_pkg;

  // Text byte codes
  localparam logic [7:0] NL_BYTE    = 8'd10;
  localparam logic [7:0] DIGIT_LOW  = 8'd48;
  localparam logic [7:0] DIGIT_HIGH = 8'd57;

  // Cell marks stored beside the labels
  localparam logic [4:0] PAD_MARK  = 5'h1F;
  localparam logic [4:0] DONE_MARK = 5'h10;

  // Datapath operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_ACCEPT  = 5'd1;
  localparam op_t OP_PAD     = 5'd2;
  localparam op_t OP_ENDROW  = 5'd3;
  localparam op_t OP_CLOSE   = 5'd4;
  localparam op_t OP_NEXTROW = 5'd5;
  localparam op_t OP_SCAN_RD = 5'd6;
  localparam op_t OP_SKIP    = 5'd7;
  localparam op_t OP_SEED    = 5'd8;
  localparam op_t OP_R_RD    = 5'd9;
  localparam op_t OP_R_INC   = 5'd10;
  localparam op_t OP_L_RD    = 5'd11;
  localparam op_t OP_L_DEC   = 5'd12;
  localparam op_t OP_U_RD    = 5'd13;
  localparam op_t OP_U_INC   = 5'd14;
  localparam op_t OP_PX_INC  = 5'd15;
  localparam op_t OP_PX_LO   = 5'd16;
  localparam op_t OP_D_RD    = 5'd17;
  localparam op_t OP_D_DEC   = 5'd18;
  localparam op_t OP_M_INIT  = 5'd19;
  localparam op_t OP_MARK    = 5'd20;
  localparam op_t OP_FIN     = 5'd21;

  typedef struct packed {
    op_t  op;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic is_fetch;
    logic is_nl;
    logic row_full;
    logic need_pad;
    logic pad_last;
    logic pending;
    logic closed;
    logic scan_end;
    logic x_past;
    logic cell_done;
    logic cell_eq;
    logic r_ok;
    logic l_ok;
    logic u_ok;
    logic d_ok;
    logic px_at_hi;
    logic py_at_top;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* sv/gre_if.sv */
// Channel interfaces for input items and result items.
`default_nettype none
interface gre_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;
  modport source (output valid, kind, text_byte, input ready);
  modport sink (input valid, kind, text_byte, output ready);
endinterface

interface gre_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [3:0] label;
  logic [5:0] x_low;
  logic [5:0] y_low;
  logic [6:0] rect_width;
  logic [6:0] rect_height;
  logic [6:0] center_x_twice;
  logic [6:0] center_y_twice;
  logic       overflow;
  modport source (output valid, found, label, x_low, y_low, rect_width, rect_height,
                  center_x_twice, center_y_twice, overflow, input ready);
  modport sink (input valid, found, label, x_low, y_low, rect_width, rect_height,
                center_x_twice, center_y_twice, overflow, output ready);
endinterface
`default_nettype wire

/* sv/gre_ctrl.sv */
// Controller state machine: sequences load, padding, scan, growth and marking.
`default_nettype none
module gre_ctrl
  import gre_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PAD    = 4'd1;
  localparam logic [3:0] S_ENDROW = 4'd2;
  localparam logic [3:0] S_CLOSE  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SCHK   = 4'd5;
  localparam logic [3:0] S_RGT    = 4'd6;
  localparam logic [3:0] S_RCHK   = 4'd7;
  localparam logic [3:0] S_LFT    = 4'd8;
  localparam logic [3:0] S_LCHK   = 4'd9;
  localparam logic [3:0] S_UP     = 4'd10;
  localparam logic [3:0] S_UCHK   = 4'd11;
  localparam logic [3:0] S_DN     = 4'd12;
  localparam logic [3:0] S_DCHK   = 4'd13;
  localparam logic [3:0] S_MARK   = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       found_r, found_nxt;
  logic       ret_r, ret_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    ret_nxt   = ret_r;
    cmd.op    = OP_NONE;
    cmd.found = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (!st.closed) begin
            if (!st.is_fetch) begin
              if (st.is_nl) begin
                ret_nxt   = 1'b0;
                state_nxt = (!st.row_full && st.need_pad) ? S_PAD : S_ENDROW;
              end
            end else if (st.pending) begin
              ret_nxt   = 1'b1;
              state_nxt = (!st.row_full && st.need_pad) ? S_PAD : S_ENDROW;
            end else begin
              state_nxt = S_CLOSE;
            end
          end else if (st.is_fetch) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_PAD: begin
        cmd.op = OP_PAD;
        if (st.pad_last) state_nxt = S_ENDROW;
      end
      S_ENDROW: begin
        cmd.op    = OP_ENDROW;
        state_nxt = ret_r ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        cmd.op    = OP_CLOSE;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_end) begin
          found_nxt = 1'b0;
          state_nxt = S_FIN;
        end else if (st.x_past) begin
          cmd.op = OP_NEXTROW;
        end else begin
          cmd.op    = OP_SCAN_RD;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (st.cell_done) begin
          cmd.op    = OP_SKIP;
          state_nxt = S_SCAN;
        end else begin
          cmd.op    = OP_SEED;
          state_nxt = S_RGT;
        end
      end
      S_RGT: begin
        if (st.r_ok) begin
          cmd.op    = OP_R_RD;
          state_nxt = S_RCHK;
        end else begin
          state_nxt = S_LFT;
        end
      end
      S_RCHK: begin
        if (st.cell_eq) begin
          cmd.op    = OP_R_INC;
          state_nxt = S_RGT;
        end else begin
          state_nxt = S_LFT;
        end
      end
      S_LFT: begin
        if (st.l_ok) begin
          cmd.op    = OP_L_RD;
          state_nxt = S_LCHK;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_LCHK: begin
        if (st.cell_eq) begin
          cmd.op    = OP_L_DEC;
          state_nxt = S_LFT;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (st.u_ok) begin
          cmd.op    = OP_U_RD;
          state_nxt = S_UCHK;
        end else begin
          cmd.op    = OP_PX_LO;
          state_nxt = S_DN;
        end
      end
      S_UCHK: begin
        if (!st.cell_eq) begin
          cmd.op    = OP_PX_LO;
          state_nxt = S_DN;
        end else begin
          cmd.op    = st.px_at_hi ? OP_U_INC : OP_PX_INC;
          state_nxt = S_UP;
        end
      end
      S_DN: begin
        if (st.d_ok) begin
          cmd.op    = OP_D_RD;
          state_nxt = S_DCHK;
        end else begin
          cmd.op    = OP_M_INIT;
          state_nxt = S_MARK;
        end
      end
      S_DCHK: begin
        if (!st.cell_eq) begin
          cmd.op    = OP_M_INIT;
          state_nxt = S_MARK;
        end else begin
          cmd.op    = st.px_at_hi ? OP_D_DEC : OP_PX_INC;
          state_nxt = S_DN;
        end
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (st.px_at_hi && st.py_at_top) begin
          found_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.op    = OP_FIN;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      found_r <= 1'b0;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/gre_dp.sv */
// Datapath: cell memory, load counters, scan position, rectangle bounds, result register.
`default_nettype none
module gre_dp
  import gre_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output stat_t           st,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic            out_found,
  output logic [3:0]      out_label,
  output logic [5:0]      out_x_low,
  output logic [5:0]      out_y_low,
  output logic [6:0]      out_width,
  output logic [6:0]      out_height,
  output logic [6:0]      out_cx2,
  output logic [6:0]      out_cy2,
  output logic            out_overflow
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [4:0]    mem [DEPTH];
  logic [4:0]    rd_r;

  logic [CW-1:0] cur_len_r, longest_r, x_r, pad_x_r;
  logic [RW-1:0] row_cnt_r, y_r;
  logic          pending_r, closed_r, ovf_r;
  logic [3:0]    pad_cfg_r, pad_lat_r, t_r;
  logic [CW-1:0] lo_r, hi_r, px_r;
  logic [RW-1:0] top_r, bot_r, py_r;

  logic          we, ld_row, digit;
  logic [4:0]    wd, cv;
  logic [CW-1:0] gx;
  logic [RW-1:0] gy, arow;
  logic [31:0]   alin;
  logic [AW-1:0] addr;
  logic [CW:0]   w_full;
  logic [RW:0]   h_full;

  assign digit = (in_byte >= DIGIT_LOW) && (in_byte <= DIGIT_HIGH);

  // Map a stored cell to its label, pad marks to the pad label latched at close
  assign cv = (rd_r == PAD_MARK) ? {1'b0, pad_lat_r} : rd_r;

  // Status to the controller
  always_comb begin
    st.is_fetch  = in_kind;
    st.is_nl     = (in_byte == NL_BYTE);
    st.row_full  = (32'(row_cnt_r) >= MAX_ROWS);
    st.need_pad  = (32'(cur_len_r) < MAX_COLS);
    st.pad_last  = (32'(pad_x_r) == MAX_COLS - 1);
    st.pending   = pending_r;
    st.closed    = closed_r;
    st.scan_end  = (y_r >= row_cnt_r);
    st.x_past    = (x_r >= longest_r);
    st.cell_done = cv[4];
    st.cell_eq   = (cv == {1'b0, t_r});
    st.r_ok      = ({1'b0, hi_r} + 1'b1) < {1'b0, longest_r};
    st.l_ok      = (lo_r != '0);
    st.u_ok      = ({1'b0, top_r} + 1'b1) < {1'b0, row_cnt_r};
    st.d_ok      = (bot_r != '0);
    st.px_at_hi  = (px_r == hi_r);
    st.py_at_top = (py_r == top_r);
    st.out_free  = !out_valid || out_ready;
  end

  // Memory address and write data for the current operation
  always_comb begin
    we     = 1'b0;
    wd     = DONE_MARK;
    ld_row = 1'b0;
    gx     = x_r;
    gy     = y_r;
    unique case (cmd.op)
      OP_ACCEPT: begin
        ld_row = 1'b1;
        gx     = cur_len_r;
        wd     = 5'(in_byte - DIGIT_LOW);
        we     = !in_kind && !closed_r && !st.is_nl && digit && !st.row_full
                 && st.need_pad;
      end
      OP_PAD: begin
        ld_row = 1'b1;
        gx     = pad_x_r;
        wd     = PAD_MARK;
        we     = 1'b1;
      end
      OP_R_RD: gx = CW'(hi_r + 1'b1);
      OP_L_RD: gx = CW'(lo_r - 1'b1);
      OP_U_RD: begin
        gx = px_r;
        gy = RW'(top_r + 1'b1);
      end
      OP_D_RD: begin
        gx = px_r;
        gy = RW'(bot_r - 1'b1);
      end
      OP_MARK: begin
        gx = px_r;
        gy = py_r;
        we = 1'b1;
      end
      default: ;
    endcase
    // y counts from the last row stored
    arow = ld_row ? row_cnt_r : RW'(row_cnt_r - 1'b1 - gy);
    alin = 32'(arow) * 32'(MAX_COLS) + 32'(gx);
    addr = AW'(alin);
  end

  // Cell memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd_r <= mem[addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r <= '0;
      longest_r <= '0;
      row_cnt_r <= '0;
      x_r       <= '0;
      y_r       <= '0;
      pending_r <= 1'b0;
      closed_r  <= 1'b0;
      ovf_r     <= 1'b0;
      pad_cfg_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) pad_cfg_r <= cfg_data;
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (!in_kind && !closed_r && !st.is_nl) begin
            pending_r <= 1'b1;
            if (digit && !st.row_full) begin
              if (st.need_pad) cur_len_r <= cur_len_r + 1'b1;
              else ovf_r <= 1'b1;
            end
          end
        end
        OP_ENDROW: begin
          if (st.row_full) begin
            ovf_r <= 1'b1;
          end else begin
            if (cur_len_r > longest_r) longest_r <= cur_len_r;
            row_cnt_r <= row_cnt_r + 1'b1;
          end
          cur_len_r <= '0;
          pending_r <= 1'b0;
        end
        OP_CLOSE: begin
          closed_r <= 1'b1;
          x_r      <= '0;
          y_r      <= '0;
        end
        OP_NEXTROW: begin
          x_r <= '0;
          y_r <= y_r + 1'b1;
        end
        OP_SKIP: x_r <= x_r + 1'b1;
        OP_FIN: if (cmd.found) x_r <= x_r + 1'b1;
        default: ;
      endcase
      // Hold the result until its transfer
      if (cmd.op == OP_FIN) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign w_full = {1'b0, hi_r} - {1'b0, lo_r} + 1'b1;
  assign h_full = {1'b0, top_r} - {1'b0, bot_r} + 1'b1;

  // Working bounds and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: pad_x_r <= cur_len_r;
      OP_PAD:    pad_x_r <= pad_x_r + 1'b1;
      OP_CLOSE:  pad_lat_r <= pad_cfg_r;
      OP_SEED: begin
        t_r   <= cv[3:0];
        lo_r  <= x_r;
        hi_r  <= x_r;
        px_r  <= x_r;
        top_r <= y_r;
        bot_r <= y_r;
      end
      OP_R_INC: hi_r <= hi_r + 1'b1;
      OP_L_DEC: begin
        lo_r <= lo_r - 1'b1;
        px_r <= lo_r - 1'b1;
      end
      OP_U_INC: begin
        top_r <= top_r + 1'b1;
        px_r  <= lo_r;
      end
      OP_D_DEC: begin
        bot_r <= bot_r - 1'b1;
        px_r  <= lo_r;
      end
      OP_PX_INC: px_r <= px_r + 1'b1;
      OP_PX_LO:  px_r <= lo_r;
      OP_M_INIT: begin
        px_r <= lo_r;
        py_r <= bot_r;
      end
      OP_MARK: begin
        if (st.px_at_hi) begin
          px_r <= lo_r;
          py_r <= py_r + 1'b1;
        end else begin
          px_r <= px_r + 1'b1;
        end
      end
      OP_FIN: begin
        out_found    <= cmd.found;
        out_overflow <= ovf_r;
        if (cmd.found) begin
          out_label  <= t_r;
          out_x_low  <= 6'(lo_r);
          out_y_low  <= 6'(bot_r);
          out_width  <= 7'(w_full);
          out_height <= 7'(h_full);
          out_cx2    <= 7'(32'(lo_r) + 32'(lo_r) + 32'(w_full));
          out_cy2    <= 7'(32'(bot_r) + 32'(bot_r) + 32'(h_full));
        end else begin
          out_label  <= '0;
          out_x_low  <= '0;
          out_y_low  <= '0;
          out_width  <= '0;
          out_height <= '0;
          out_cx2    <= '0;
          out_cy2    <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* sv/grid_rectangle_extractor_unit.sv */
// Top level of the grid rectangle extractor.
//
// Input channel in_if carries kind and text_byte. kind 0 loads a text byte: digits
// become cells, byte 10 ends a row, other bytes only open a row. kind 1 fetches the
// next rectangle and returns exactly one result on out_if; text bytes give none.
// cfg_we/cfg_data write the pad label, applied when the first fetch closes the load.
// A newline pads the row with pad cells (MAX_COLS - row length, none once the row or
// the row count is full) and then closes the row. The first fetch closes the load,
// after padding an unfinished last row the same way. A fetch walks the grid through
// one registered memory read: it scans for an unmarked cell, grows the rectangle
// right, left, up and down while the probed cells match, marks its cells and loads
// the result. One item is in work at a time; in_if.ready is high only while idle.
// The result sits in an output register, so the next item is taken while it waits;
// a second fetch finishing before the first result's transfer holds until it goes.
// Reset (rst_n low, synchronous) empties the grid, clears counters, flags and the
// pad label; the cell memory itself is not cleared and needs no sweep.
`default_nettype none
module grid_rectangle_extractor_unit
  import gre_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  gre_in_if.sink          in_if,
  gre_out_if.source       out_if,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  gre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gre_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_kind      (in_if.kind),
    .in_byte      (in_if.text_byte),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_found    (out_if.found),
    .out_label    (out_if.label),
    .out_x_low    (out_if.x_low),
    .out_y_low    (out_if.y_low),
    .out_width    (out_if.rect_width),
    .out_height   (out_if.rect_height),
    .out_cx2      (out_if.center_x_twice),
    .out_cy2      (out_if.center_y_twice),
    .out_overflow (out_if.overflow)
  );

endmodule
`default_nettype wire
